@@ rtl/rvq_pkg.sv @@
// Shared constants, types and helper functions for the rotation vector to quaternion block.
`timescale 1ns / 1ps
`default_nettype none

package rvq_pkg;

  // Default number of CORDIC rotations.
  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // Fixed-point constants, Q30 unless noted.
  localparam logic [31:0]        Q30_ONE     = 32'h4000_0000;
  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic [36:0]        Q30_TWO_PI  = 37'd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Reset value of the zero tolerance register (Q8.24).
  localparam logic [23:0] TOL_RESET = 24'd1678;

  // Register byte addresses.
  localparam logic [1:0] REG_ZERO_TOL = 2'd0;

  // Information that travels beside the arithmetic through the pipeline.
  typedef struct packed {
    logic             near_zero;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [31:0]      angle;
    logic [31:0]      w;
  } side_t;

  // Truncated Q30 arctangent of 2^-idx.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rotation_vector_to_quaternion.sv @@
// Top level: pipelined rotation vector to unit quaternion converter.
//
// Usage: a rotation vector (rot_x, rot_y, rot_z, signed Q8.24 radians) enters on the
// in_ channel and one unit quaternion (w, x, y, z, signed Q2.30) leaves on the out_
// channel for every item, in order. Both channels use valid/ready.
// The zero_tolerance register sits at byte address 0 of the APB-style port.
// Throughput: one item per cycle while the receiver keeps taking results. The depth
// is mostly the 32-stage square root, the five modulo stages, one stage per CORDIC
// rotation and the 32-stage divider that scales the vector part.
// The whole pipeline advances whenever the output register is empty or being
// taken, so a stall at the receiver holds every stage in place and in_ready drops;
// nothing is lost or repeated.
// Reset clears all valid bits and sets zero_tolerance to 1678 (about 1e-4).
`timescale 1ns / 1ps
`default_nettype none

module rotation_vector_to_quaternion #(
  parameter int unsigned CORDIC_STEPS = rvq_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_rot_x,
  input  wire logic signed [31:0] in_rot_y,
  input  wire logic signed [31:0] in_rot_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_quat_w,
  output logic signed [31:0]      out_quat_x,
  output logic signed [31:0]      out_quat_y,
  output logic signed [31:0]      out_quat_z,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import rvq_pkg::*;

  localparam int unsigned SQ_STAGES  = 32;
  localparam int unsigned MOD_STAGES = 5;
  localparam int unsigned DIV_STAGES = 32;
  localparam int unsigned LAT = 3 + SQ_STAGES + MOD_STAGES + 2 + CORDIC_STEPS + 3
                                + DIV_STAGES + 1;

  // Configuration register.
  logic [23:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_ZERO_TOL)) begin
      tol_r <= pwdata[23:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ZERO_TOL) ? {8'd0, tol_r} : 32'd0;

  // Pipeline advance and valid bits.
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Input stage: capture the components.
  logic signed [31:0] a_c_r [3];
  logic [2:0][31:0]   a_m;

  always_ff @(posedge clk) begin
    if (en) begin
      a_c_r[0] <= in_rot_x;
      a_c_r[1] <= in_rot_y;
      a_c_r[2] <= in_rot_z;
    end
  end

  // Magnitudes; the most negative value maps to 2^31.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_m[k] = a_c_r[k][31] ? (~a_c_r[k] + 32'd1) : a_c_r[k];
    end
  end

  // Squares and near-zero test.
  logic [63:0] b_sq_r [3];
  side_t       b_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        b_sq_r[k] <= a_m[k] * a_m[k];
      end
      b_sd_r.near_zero <= (a_m[0] < {8'd0, tol_r}) && (a_m[1] < {8'd0, tol_r})
                          && (a_m[2] < {8'd0, tol_r});
      b_sd_r.neg   <= {a_c_r[2][31], a_c_r[1][31], a_c_r[0][31]};
      b_sd_r.mag   <= a_m;
      b_sd_r.angle <= '0;
      b_sd_r.w     <= '0;
    end
  end

  // Sum of squares.
  logic [63:0] c_sum_r;
  side_t       c_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_sum_r <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      c_sd_r  <= b_sd_r;
    end
  end

  // Square root, one result bit per stage.
  logic [63:0] sr_rad_r  [SQ_STAGES];
  logic [32:0] sr_rem_r  [SQ_STAGES];
  logic [31:0] sr_root_r [SQ_STAGES];
  side_t       sr_sd_r   [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [63:0] rad_i;
    logic [32:0] rem_i;
    logic [31:0] root_i;
    side_t       sd_i;
    logic [34:0] rem_t;
    logic [34:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rad_i  = c_sum_r;
      assign rem_i  = '0;
      assign root_i = '0;
      assign sd_i   = c_sd_r;
    end else begin : g_next
      assign rad_i  = sr_rad_r[k-1];
      assign rem_i  = sr_rem_r[k-1];
      assign root_i = sr_root_r[k-1];
      assign sd_i   = sr_sd_r[k-1];
    end

    assign rem_t = {rem_i, rad_i[63:62]};
    assign trial = {1'b0, root_i, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sr_rem_r[k]  <= ge ? 33'(rem_t - trial) : rem_t[32:0];
        sr_root_r[k] <= {root_i[30:0], ge};
        sr_rad_r[k]  <= {rad_i[61:0], 2'b00};
        sr_sd_r[k]   <= sd_i;
      end
    end
  end

  // Half angle reduced modulo 2*pi by conditional subtraction of 2*pi times 16..1.
  logic [36:0] md_h_r  [MOD_STAGES];
  side_t       md_sd_r [MOD_STAGES];

  for (genvar j = 0; j < MOD_STAGES; j++) begin : g_mod
    localparam logic [36:0] THR = Q30_TWO_PI << (MOD_STAGES - 1 - j);
    logic [36:0] h_i;
    side_t       sd_i;

    if (j == 0) begin : g_first
      assign h_i = {sr_root_r[SQ_STAGES-1], 5'b00000};
      always_comb begin
        sd_i       = sr_sd_r[SQ_STAGES-1];
        sd_i.angle = sr_root_r[SQ_STAGES-1];
      end
    end else begin : g_next
      assign h_i  = md_h_r[j-1];
      assign sd_i = md_sd_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        md_h_r[j]  <= (h_i >= THR) ? (h_i - THR) : h_i;
        md_sd_r[j] <= sd_i;
      end
    end
  end

  // Wrap into (-pi, pi].
  logic signed [34:0] wr_r;
  side_t              wr_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wr_r    <= (md_h_r[MOD_STAGES-1] > 37'(Q30_PI))
                 ? $signed(35'(md_h_r[MOD_STAGES-1]) - 35'(Q30_TWO_PI))
                 : $signed(35'(md_h_r[MOD_STAGES-1]));
      wr_sd_r <= md_sd_r[MOD_STAGES-1];
    end
  end

  // Fold into [-pi/2, pi/2]; folding negates sine and cosine.
  logic signed [34:0] fz_r;
  logic               fflip_r;
  side_t              f_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_r > Q30_HALF_PI) begin
        fz_r    <= wr_r - Q30_PI;
        fflip_r <= 1'b1;
      end else if (wr_r < -Q30_HALF_PI) begin
        fz_r    <= wr_r + Q30_PI;
        fflip_r <= 1'b1;
      end else begin
        fz_r    <= wr_r;
        fflip_r <= 1'b0;
      end
      f_sd_r <= wr_sd_r;
    end
  end

  // CORDIC rotations, one per stage.
  logic signed [33:0] cx_r    [CORDIC_STEPS];
  logic signed [33:0] cy_r    [CORDIC_STEPS];
  logic signed [34:0] cz_r    [CORDIC_STEPS];
  logic               cflip_r [CORDIC_STEPS];
  side_t              c_sdp_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [33:0] x_i;
    logic signed [33:0] y_i;
    logic signed [34:0] z_i;
    logic               flip_i;
    side_t              sd_i;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [34:0] ang;

    if (i == 0) begin : g_first
      assign x_i    = CORDIC_GAIN;
      assign y_i    = '0;
      assign z_i    = fz_r;
      assign flip_i = fflip_r;
      assign sd_i   = f_sd_r;
    end else begin : g_next
      assign x_i    = cx_r[i-1];
      assign y_i    = cy_r[i-1];
      assign z_i    = cz_r[i-1];
      assign flip_i = cflip_r[i-1];
      assign sd_i   = c_sdp_r[i-1];
    end

    assign dx  = y_i >>> i;
    assign dy  = x_i >>> i;
    assign ang = $signed({3'b000, atan_q30(5'(i))});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_i[34]) begin
          cx_r[i] <= x_i - dx;
          cy_r[i] <= y_i + dy;
          cz_r[i] <= z_i - ang;
        end else begin
          cx_r[i] <= x_i + dx;
          cy_r[i] <= y_i - dy;
          cz_r[i] <= z_i + ang;
        end
        cflip_r[i] <= flip_i;
        c_sdp_r[i] <= sd_i;
      end
    end
  end

  // Post processing: cosine with sign and saturation, sine magnitude and lane signs.
  logic signed [33:0] fin_x;
  logic signed [33:0] fin_y;
  logic               fin_flip;
  logic [32:0]        p1_smag_r;
  side_t              p1_sd_nxt;
  side_t              p1_sd_r;

  assign fin_x    = cx_r[CORDIC_STEPS-1];
  assign fin_y    = cy_r[CORDIC_STEPS-1];
  assign fin_flip = cflip_r[CORDIC_STEPS-1];

  always_comb begin
    p1_sd_nxt     = c_sdp_r[CORDIC_STEPS-1];
    p1_sd_nxt.w   = sat32(fin_flip ? -fin_x : fin_x);
    p1_sd_nxt.neg = c_sdp_r[CORDIC_STEPS-1].neg
                    ^ {3{(fin_flip ^ fin_y[33]) && (fin_y != '0)}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_smag_r <= fin_y[33] ? 33'(-fin_y) : 33'(fin_y);
      p1_sd_r   <= p1_sd_nxt;
    end
  end

  // Products of the sine magnitude and the component magnitudes.
  logic [63:0] p2_num_r [3];
  side_t       p2_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p2_num_r[k] <= 64'(p1_smag_r * p1_sd_r.mag[k]);
      end
      p2_sd_r <= p1_sd_r;
    end
  end

  // Rounding offset of half the divisor.
  logic [63:0] p3_num_r [3];
  side_t       p3_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p3_num_r[k] <= p2_num_r[k] + {33'd0, p2_sd_r.angle[31:1]};
      end
      p3_sd_r <= p2_sd_r;
    end
  end

  // Restoring division by the angle, one quotient bit per stage in each lane.
  logic [63:0] dv_rem_r [DIV_STAGES][3];
  logic [31:0] dv_q_r   [DIV_STAGES][3];
  side_t       dv_sd_r  [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int unsigned BIT = DIV_STAGES - 1 - j;
    logic [63:0] den_sh;
    side_t       sd_i;

    if (j == 0) begin : g_first
      assign sd_i = p3_sd_r;
    end else begin : g_next
      assign sd_i = dv_sd_r[j-1];
    end

    assign den_sh = {32'd0, sd_i.angle} << BIT;

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [63:0] rem_i;
      logic [31:0] q_i;
      logic        ge;

      if (j == 0) begin : g_first
        assign rem_i = p3_num_r[k];
        assign q_i   = '0;
      end else begin : g_next
        assign rem_i = dv_rem_r[j-1][k];
        assign q_i   = dv_q_r[j-1][k];
      end

      assign ge = rem_i >= den_sh;

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[j][k] <= ge ? (rem_i - den_sh) : rem_i;
          dv_q_r[j][k]   <= {q_i[30:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_sd_r[j] <= sd_i;
      end
    end
  end

  // Output register: identity near zero, else signed saturated parts, zeroed at angle 0.
  side_t              o_sd;
  logic               o_zero;
  logic [31:0]        o_part [3];
  logic signed [33:0] o_sq   [3];
  logic [31:0]        q_w_r;
  logic [31:0]        q_v_r  [3];

  assign o_sd   = dv_sd_r[DIV_STAGES-1];
  assign o_zero = o_sd.near_zero || (o_sd.angle == '0);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      o_sq[k]   = $signed({2'b00, dv_q_r[DIV_STAGES-1][k]});
      o_part[k] = sat32(o_sd.neg[k] ? -o_sq[k] : o_sq[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_w_r <= o_sd.near_zero ? Q30_ONE : o_sd.w;
      for (int k = 0; k < 3; k++) begin
        q_v_r[k] <= o_zero ? 32'd0 : o_part[k];
      end
    end
  end

  assign out_quat_w = $signed(q_w_r);
  assign out_quat_x = $signed(q_v_r[0]);
  assign out_quat_y = $signed(q_v_r[1]);
  assign out_quat_z = $signed(q_v_r[2]);

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for the rotation vector to quaternion converter: random and directed items.
`timescale 1ns / 1ps

// Holds expected quaternions in order and compares each accepted result against them.
class quat_scoreboard;
  logic [31:0] exp_w[$], exp_x[$], exp_y[$], exp_z[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function void note_item(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    exp_w.push_back(w);
    exp_x.push_back(x);
    exp_y.push_back(y);
    exp_z.push_back(z);
  endfunction

  function void check_result(logic [31:0] w, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
    logic [31:0] ew, ex, ey, ez;
    if (exp_w.size() == 0) begin
      $error("unexpected quaternion w=%h x=%h y=%h z=%h", w, x, y, z);
      errors++;
      return;
    end
    ew = exp_w.pop_front();
    ex = exp_x.pop_front();
    ey = exp_y.pop_front();
    ez = exp_z.pop_front();
    if (w !== ew) begin
      $error("quat_w expected %h actual %h", ew, w);
      errors++;
    end
    if (x !== ex) begin
      $error("quat_x expected %h actual %h", ex, x);
      errors++;
    end
    if (y !== ey) begin
      $error("quat_y expected %h actual %h", ey, y);
      errors++;
    end
    if (z !== ez) begin
      $error("quat_z expected %h actual %h", ez, z);
      errors++;
    end
  endfunction

  function int pending();
    return exp_w.size();
  endfunction
endclass

module tb_top;
  import rvq_pkg::*;

  localparam int NUM_RANDOM = 1300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam longint TWO_PI = 64'd6746518852;
  localparam longint PI_Q30 = 64'd3373259426;
  localparam longint HALF_PI = 64'd1686629713;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_rot_x = '0, in_rot_y = '0, in_rot_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  quat_scoreboard sb;
  logic [23:0] tolerance;
  logic calm_phase = 1'b0;
  logic long_hold = 1'b0;
  int idle_count = 0;

  rotation_vector_to_quaternion u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rot_x(in_rot_x), .in_rot_y(in_rot_y), .in_rot_z(in_rot_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Arithmetic right shift rounding toward minus infinity.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Square root of a 64-bit value, rounded down.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Works out the quaternion for one rotation vector and the current tolerance.
  task automatic predict_quaternion(logic signed [31:0] rx, logic signed [31:0] ry,
                                    logic signed [31:0] rz);
    longint comp[3];
    longint unsigned mag, sum, ang, num, q;
    longint half, cx, cy, cz, dx, dy;
    logic near_zero, flip;
    logic [31:0] parts[3];
    comp[0] = rx;
    comp[1] = ry;
    comp[2] = rz;
    sum = 0;
    near_zero = 1'b1;
    for (int k = 0; k < 3; k++) begin
      mag = comp[k] < 0 ? -comp[k] : comp[k];
      if (mag >= tolerance) near_zero = 1'b0;
      sum += mag * mag;
    end
    if (near_zero) begin
      sb.note_item(Q30_ONE, '0, '0, '0);
      return;
    end
    ang = root_floor(sum);
    half = longint'((ang << 5) % TWO_PI);
    if (half > PI_Q30) half -= TWO_PI;
    flip = 1'b0;
    if (half > HALF_PI) begin
      half -= PI_Q30;
      flip = 1'b1;
    end else if (half < -HALF_PI) begin
      half += PI_Q30;
      flip = 1'b1;
    end
    // CORDIC rotation mode from gain-scaled unit vector.
    cx = 652032874;
    cy = 0;
    cz = half;
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      if (cz >= 0) begin
        cx -= dx;
        cy += dy;
        cz -= longint'(atan_q30(i[4:0]));
      end else begin
        cx += dx;
        cy -= dy;
        cz += longint'(atan_q30(i[4:0]));
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    for (int k = 0; k < 3; k++) begin
      if (ang == 0) begin
        parts[k] = '0;
      end else begin
        num = longint'(cy < 0 ? -cy : cy) * longint'(comp[k] < 0 ? -comp[k] : comp[k]);
        q = (num + ang / 2) / ang;
        parts[k] = clamp32(((cy < 0) != (comp[k] < 0)) ? -longint'(q) : longint'(q));
      end
    end
    sb.note_item(clamp32(cx), parts[0], parts[1], parts[2]);
  endtask

  task automatic write_tolerance(logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_ZERO_TOL;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tolerance = value[23:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offers one item, holding it until accepted, with an optional idle burst first.
  task automatic send_rotation(logic signed [31:0] rx, logic signed [31:0] ry,
                               logic signed [31:0] rz);
    int gap;
    if (!calm_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rot_x <= rx;
    in_rot_y <= ry;
    in_rot_z <= rz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_quaternion(rx, ry, rz);
    @(negedge clk);
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random component: mostly within a few radians, sometimes full range or tiny.
  function automatic logic signed [31:0] pick_component();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 4000)) - 2000;
      default: return $signed($urandom_range(0, 32'h0C00_0000)) - 32'sh0600_0000;
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold, and none at the end.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checking on the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_quat_w, out_quat_x, out_quat_y, out_quat_z);
  end

  // Watchdog on cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    logic [31:0] tol_settings[4];
    sb = new();
    tolerance = TOL_RESET;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, near-zero and the most negative component.
    send_rotation(0, 0, 0);
    send_rotation(1677, -1677, 0);
    send_rotation(1678, 0, 0);
    send_rotation(32'sh8000_0000, 0, 0);
    send_rotation(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_rotation(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_rotation(32'sh0100_0000, 0, 0);
    send_rotation(0, 32'sh0324_3F6A, 0);
    send_rotation(0, 0, -32'sh0648_7ED5);
    send_rotation(32'sh0648_7ED5, 0, 0);
    send_rotation(-1, -1, -1);
    send_rotation(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    send_rotation(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0);
    wait_drained();

    // Tolerance of zero: all-zero vector goes through the CORDIC path.
    write_tolerance(32'd0);
    send_rotation(0, 0, 0);
    send_rotation(1, 0, -1);
    wait_drained();

    // Random phases across tolerance settings, the largest among them.
    tol_settings = '{32'hFF_FFFF, 32'd0, 32'd4000, 32'(TOL_RESET)};
    for (int p = 0; p < 4; p++) begin
      write_tolerance(tol_settings[p]);
      if (p == 3) calm_phase = 1'b1;
      if (p == 1) long_hold = 1'b1;
      for (int n = 0; n < NUM_RANDOM / 4; n++)
        send_rotation(pick_component(), pick_component(), pick_component());
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
